// ----- rtl/tkps_pkg.sv -----
// Shared types and constants for the top-k priority select block.
package tkps_pkg;

  // Number of slot cells in the row; the rank and count fields are sized for it
  localparam int MAX_SELECT = 16;

  // Fixed field widths of the configuration and result words
  localparam int TOP_COUNT_W = 5;
  localparam int RANK_W      = 4;
  localparam int COUNT_W     = 5;

  localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET = 5'd16;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_COUNT = 3'b010,
    ST_EMIT  = 3'b100
  } tkps_state_t;

  // Commands broadcast from the sequencer to every slot cell
  typedef struct packed {
    logic ins;    // insert the broadcast entry
    logic drain;  // shift the whole row one place toward rank 0
    logic clr;    // empty every slot
  } tkps_cell_ctrl_t;

endpackage

// ----- rtl/tkps_cell.sv -----
// One slot of the sorted list: compares, inserts and shifts with its neighbors.
module tkps_cell #(
  parameter int IDX_W = 12,
  parameter int PRI_W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tkps_pkg::tkps_cell_ctrl_t ctrl,
  input  logic                      active,
  input  logic [IDX_W-1:0]          new_idx,
  input  logic [PRI_W-1:0]          new_pri,
  input  logic [IDX_W-1:0]          left_idx,
  input  logic [PRI_W-1:0]          left_pri,
  input  logic                      left_vld,
  input  logic [IDX_W-1:0]          right_idx,
  input  logic [PRI_W-1:0]          right_pri,
  input  logic                      right_vld,
  input  logic                      pass_in,
  output logic                      pass_out,
  output logic [IDX_W-1:0]          idx,
  output logic [PRI_W-1:0]          pri,
  output logic                      vld
);
  import tkps_pkg::*;

  logic hit;

  // Entry belongs here if the slot is empty or holds strictly lower priority
  assign hit      = active && (!vld || (new_pri > pri));
  assign pass_out = pass_in || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctrl.clr) begin
      vld <= 1'b0;
    end else if (ctrl.drain) begin
      vld <= right_vld;
      idx <= right_idx;
      pri <= right_pri;
    end else if (ctrl.ins && active) begin
      if (pass_in) begin
        // insertion point lies ahead: take the neighbor's slot
        vld <= left_vld;
        idx <= left_idx;
        pri <= left_pri;
      end else if (hit) begin
        vld <= 1'b1;
        idx <= new_idx;
        pri <= new_pri;
      end
    end
  end

endmodule

// ----- rtl/top_k_priority_select.sv -----
// Top level of the streaming top-k priority select block.
//
// The block scans table entries, one word per cycle while idle, and keeps
// the top_count present entries with the highest priority in a row of slot
// cells sorted by descending priority; equal priorities keep arrival order
// and an entry that is not above any full slot is dropped. A non-final
// entry leaves the block idle, and a new one is taken in the next cycle. An
// entry with last_entry set is inserted, then a count state records the
// filled ranks, then the block emits top_count result words from rank 0
// upward, one per cycle while out_ready is high; it takes no input until the
// final result word is taken. Each entry is compared against every slot at
// once in the row of cells, and results drain out of cell 0 as the row
// shifts toward it. top_count of zero acts as one, and values above
// MAX_SELECT saturate. After the last result all slots empty.
module top_k_priority_select #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [tkps_pkg::TOP_COUNT_W-1:0]     cfg_wr_data,
  // entry words
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]     entry_index,
  input  logic [PRIORITY_BITS-1:0]             entry_priority,
  input  logic                                 entry_present,
  input  logic                                 last_entry,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tkps_pkg::RANK_W-1:0]          rank,
  output logic                                 slot_filled,
  output logic [$clog2(TABLE_ENTRIES)-1:0]     chosen_index,
  output logic [PRIORITY_BITS-1:0]             chosen_priority,
  output logic [tkps_pkg::COUNT_W-1:0]         selected_count,
  output logic                                 last_result
);
  import tkps_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int PRI_W = PRIORITY_BITS;
  localparam int KW    = $clog2(MAX_SELECT + 1);

  // Registers
  logic [TOP_COUNT_W-1:0] top_count;
  tkps_state_t            state, state_next;
  logic [KW-1:0]          emit_rank, emit_rank_next;
  logic [KW-1:0]          sel_count, sel_count_next;

  // Handshake and control
  logic            in_fire, out_fire;
  logic [KW-1:0]   k;
  logic [KW-1:0]   k_last;
  logic [KW-1:0]   filled;
  tkps_cell_ctrl_t cell_ctrl;

  // Cell row
  logic [IDX_W-1:0] c_idx  [MAX_SELECT];
  logic [PRI_W-1:0] c_pri  [MAX_SELECT];
  logic             c_vld  [MAX_SELECT];
  logic             c_pass [MAX_SELECT];
  logic             c_act  [MAX_SELECT];

  // Hold the selection size; write it only while idle: the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= TOP_COUNT_RESET;
    end else if (cfg_wr_en) begin
      top_count <= cfg_wr_data;
    end
  end

  // Active slot count: zero acts as one, saturate at the cell count
  always_comb begin
    if (top_count == '0) begin
      k = KW'(1);
    end else if (int'(top_count) > MAX_SELECT) begin
      k = KW'(MAX_SELECT);
    end else begin
      k = KW'(top_count);
    end
  end

  assign k_last = k - KW'(1);

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // Insert on every present entry; drain toward rank 0 as results leave;
  // empty the row once the final result is taken
  always_comb begin
    cell_ctrl.ins   = in_fire && entry_present;
    cell_ctrl.drain = out_fire && !last_result;
    cell_ctrl.clr   = out_fire && last_result;
  end

  // Row of slot cells, rank 0 at the left
  for (genvar j = 0; j < MAX_SELECT; j++) begin : g_cell
    logic [IDX_W-1:0] l_idx, r_idx;
    logic [PRI_W-1:0] l_pri, r_pri;
    logic             l_vld, r_vld, p_in;

    assign c_act[j] = (KW'(j) < k);

    if (j == 0) begin : g_head
      assign l_idx = '0;
      assign l_pri = '0;
      assign l_vld = 1'b0;
      assign p_in  = 1'b0;
    end else begin : g_body
      assign l_idx = c_idx[j-1];
      assign l_pri = c_pri[j-1];
      assign l_vld = c_vld[j-1];
      assign p_in  = c_pass[j-1];
    end

    if (j == MAX_SELECT - 1) begin : g_tail
      assign r_idx = '0;
      assign r_pri = '0;
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_idx = c_idx[j+1];
      assign r_pri = c_pri[j+1];
      assign r_vld = c_vld[j+1];
    end

    tkps_cell #(
      .IDX_W (IDX_W),
      .PRI_W (PRI_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .active    (c_act[j]),
      .new_idx   (entry_index),
      .new_pri   (entry_priority),
      .left_idx  (l_idx),
      .left_pri  (l_pri),
      .left_vld  (l_vld),
      .right_idx (r_idx),
      .right_pri (r_pri),
      .right_vld (r_vld),
      .pass_in   (p_in),
      .pass_out  (c_pass[j]),
      .idx       (c_idx[j]),
      .pri       (c_pri[j]),
      .vld       (c_vld[j])
    );
  end

  // Count filled slots among the active ranks
  always_comb begin
    filled = '0;
    for (int j = 0; j < MAX_SELECT; j++) begin
      filled = filled + KW'(c_vld[j] && c_act[j]);
    end
  end

  // Sequencer: accept entries, count after the last one, then emit
  always_comb begin
    state_next     = state;
    emit_rank_next = emit_rank;
    sel_count_next = sel_count;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && last_entry) begin
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        sel_count_next = filled;
        emit_rank_next = '0;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (last_result) begin
            emit_rank_next = '0;
            state_next     = ST_IDLE;
          end else begin
            emit_rank_next = emit_rank + KW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      emit_rank <= '0;
      sel_count <= '0;
    end else begin
      state     <= state_next;
      emit_rank <= emit_rank_next;
      sel_count <= sel_count_next;
    end
  end

  // Result word comes straight from cell 0 and the sequencer registers
  assign rank            = RANK_W'(emit_rank);
  assign slot_filled     = c_vld[0];
  assign chosen_index    = c_vld[0] ? c_idx[0] : '0;
  assign chosen_priority = c_vld[0] ? c_pri[0] : '0;
  assign selected_count  = COUNT_W'(sel_count);
  assign last_result     = (emit_rank == k_last);

  // A final result returns the block to taking entries
  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_result |=> in_ready && !out_valid)
    else $error("block not idle after final result");

  // A last entry stops intake and holds results back during the count state
  a_last_stops_intake: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_entry |=> !in_ready && !out_valid)
    else $error("intake continued after last entry");

  // The selected count holds across all results of one run
  a_count_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=> out_valid && $stable(selected_count))
    else $error("selected count changed mid run");

  // Every run starts at rank 0
  a_first_rank: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> rank == '0)
    else $error("run did not start at rank 0");

endmodule

// ----- verif/top_k_priority_select_tb.sv -----
// Self-checking testbench for the top-k priority select block: table-driven and random scans.
`timescale 1ns / 1ps

module top_k_priority_select_tb;
  import tkps_pkg::*;

  localparam int SLOTS        = 16;
  localparam int IDX_W        = 12;
  localparam int PRIO_W       = 16;
  localparam int RANDOM_ITEMS = 200;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 20;

  // One result word as the block should present it
  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic               filled;
    logic [IDX_W-1:0]   index;
    logic [PRIO_W-1:0]  prio;
    logic [COUNT_W-1:0] count;
    logic               last;
  } ranked_word_t;

  // One entry word, with an optional top_count write ahead of it and an
  // optional typed-in expectation for the count and rank 0 of its scan
  typedef struct packed {
    logic                   cfg_wr;
    logic [TOP_COUNT_W-1:0] cfg_val;
    logic [IDX_W-1:0]       index;
    logic [PRIO_W-1:0]      prio;
    logic                   present;
    logic                   last;
    logic                   known;
    logic [COUNT_W-1:0]     known_count;
    logic [IDX_W-1:0]       known_index;
    logic [PRIO_W-1:0]      known_prio;
  } entry_row_t;

  // Shapes of priority used by the random scans
  typedef enum logic [1:0] {
    PRIO_SPREAD,  // full range
    PRIO_TIES,    // a handful of values, many equal priorities
    PRIO_EDGES    // mostly the ends and the middle of the range
  } prio_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [TOP_COUNT_W-1:0] cfg_wr_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [IDX_W-1:0]       entry_index;
  logic [PRIO_W-1:0]      entry_priority;
  logic                   entry_present;
  logic                   last_entry;
  logic                   out_valid;
  logic                   out_ready;
  logic [RANK_W-1:0]      rank;
  logic                   slot_filled;
  logic [IDX_W-1:0]       chosen_index;
  logic [PRIO_W-1:0]      chosen_priority;
  logic [COUNT_W-1:0]     selected_count;
  logic                   last_result;

  // The configuration port writes a single register: top_count
  top_k_priority_select u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .entry_index     (entry_index),
    .entry_priority  (entry_priority),
    .entry_present   (entry_present),
    .last_entry      (last_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .rank            (rank),
    .slot_filled     (slot_filled),
    .chosen_index    (chosen_index),
    .chosen_priority (chosen_priority),
    .selected_count  (selected_count),
    .last_result     (last_result)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Ranking predictor: its own copy of top_count and of the slot row
  // ---------------------------------------------------------------------------
  logic [TOP_COUNT_W-1:0] model_top_count;
  logic [IDX_W-1:0]       slot_index [SLOTS];
  logic [PRIO_W-1:0]      slot_prio  [SLOTS];
  bit                     slot_used  [SLOTS];
  ranked_word_t           ranking_q[$];   // result words still owed by the block
  int                     mismatches;

  // Zero acts as one, anything above the row length saturates
  function automatic int active_ranks();
    if (model_top_count == 0) return 1;
    if (model_top_count > SLOTS) return SLOTS;
    return int'(model_top_count);
  endfunction

  task automatic clear_slots();
    for (int j = 0; j < SLOTS; j++) begin
      slot_index[j] = '0;
      slot_prio[j]  = '0;
      slot_used[j]  = 1'b0;
    end
  endtask

  // Place the entry ahead of the first empty slot or the first strictly lower
  // one; shift the rest of the active slots down and drop the one that falls
  // off. Slots past the active count stay as they are.
  task automatic insert_ranked(logic [IDX_W-1:0] idx, logic [PRIO_W-1:0] prio, int k);
    for (int j = 0; j < k; j++) begin
      if (!slot_used[j] || prio > slot_prio[j]) begin
        for (int m = k - 1; m > j; m--) begin
          slot_index[m] = slot_index[m-1];
          slot_prio[m]  = slot_prio[m-1];
          slot_used[m]  = slot_used[m-1];
        end
        slot_index[j] = idx;
        slot_prio[j]  = prio;
        slot_used[j]  = 1'b1;
        return;
      end
    end
  endtask

  // Advance the predictor by one accepted entry word; on the last entry of a
  // scan queue one word per active rank and empty the row.
  task automatic predict_ranking(entry_row_t r);
    int           k;
    int           filled_ranks;
    ranked_word_t w;
    k = active_ranks();
    if (r.present) insert_ranked(r.index, r.prio, k);
    if (r.last) begin
      filled_ranks = 0;
      for (int j = 0; j < k; j++) filled_ranks += slot_used[j];
      for (int j = 0; j < k; j++) begin
        w.rank   = RANK_W'(j);
        w.filled = slot_used[j];
        w.index  = slot_used[j] ? slot_index[j] : '0;
        w.prio   = slot_used[j] ? slot_prio[j] : '0;
        w.count  = COUNT_W'(filled_ranks);
        w.last   = (j == k - 1);
        // typed-in rows take their count and rank 0 straight from the table
        if (r.known) begin
          w.count = r.known_count;
          if (j == 0) begin
            w.filled = (r.known_count != 0);
            w.index  = r.known_index;
            w.prio   = r.known_prio;
          end
        end
        ranking_q.push_back(w);
      end
      clear_slots();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  bit quiet_in;    // no gaps between entry words
  bit quiet_out;   // no stalls on the result side

  // Mostly back to back, sometimes a short gap, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (quiet_in) return 0;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one entry word, hold it until taken, then feed the predictor.
  // Valid is lowered only when a gap follows, so it never drops and rises
  // within one time step.
  task automatic send_entry(entry_row_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    entry_index    <= r.index;
    entry_priority <= r.prio;
    entry_present  <= r.present;
    last_entry     <= r.last;
    do @(posedge clk); while (!in_ready);
    predict_ranking(r);
  endtask

  // Drop valid and hold until every owed word is out, then let the block
  // finish an entry that owes no word.
  task automatic settle();
    in_valid <= 1'b0;
    while (ranking_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_top_count(logic [TOP_COUNT_W-1:0] val);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    model_top_count = val;
  endtask

  function automatic logic [TOP_COUNT_W-1:0] pick_top_count();
    case ($urandom_range(0, 5))
      0:       return '0;       // acts as one
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'd31;    // saturates
      default: return TOP_COUNT_W'($urandom_range(2, 15));
    endcase
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio(prio_mode_t mode);
    case (mode)
      PRIO_TIES:  return PRIO_W'($urandom_range(0, 3));
      PRIO_EDGES: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 16'h8000;
          default: return PRIO_W'($urandom_range(0, 65535));
        endcase
      end
      default:    return PRIO_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic entry_row_t mk_row(
    logic cfg_wr, logic [TOP_COUNT_W-1:0] cfg_val,
    logic [IDX_W-1:0] idx, logic [PRIO_W-1:0] prio, logic present, logic last,
    logic known, logic [COUNT_W-1:0] kc, logic [IDX_W-1:0] ki, logic [PRIO_W-1:0] kp);
    entry_row_t r;
    r.cfg_wr      = cfg_wr;
    r.cfg_val     = cfg_val;
    r.index       = idx;
    r.prio        = prio;
    r.present     = present;
    r.last        = last;
    r.known       = known;
    r.known_count = kc;
    r.known_index = ki;
    r.known_prio  = kp;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls and the word check
  // ---------------------------------------------------------------------------
  int ready_run;
  bit ready_level;

  // Hold out_ready at one level for a run of cycles, then pick another run;
  // most stalls are short, a few are long.
  always @(posedge clk) begin
    if (quiet_out) begin
      out_ready <= 1'b1;
    end else begin
      if (ready_run == 0) begin
        ready_level = ($urandom_range(0, 2) != 0);
        if (ready_level) ready_run = $urandom_range(1, 8);
        else if ($urandom_range(0, 7) == 0) ready_run = $urandom_range(10, 40);
        else ready_run = $urandom_range(1, 3);
      end
      ready_run--;
      out_ready <= ready_level;
    end
  end

  // Compare each taken result word with the oldest owed one
  always @(posedge clk) begin : result_check
    ranked_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (ranking_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: rank %0d index %0d priority %0d",
                   rank, chosen_index, chosen_priority);
      end else begin
        want = ranking_q.pop_front();
        if (rank !== want.rank || slot_filled !== want.filled ||
            chosen_index !== want.index || chosen_priority !== want.prio ||
            selected_count !== want.count || last_result !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected rank %0d filled %0d index %0d priority %0d count %0d last %0d",
                     want.rank, want.filled, want.index, want.prio, want.count, want.last);
            $display("  actual   rank %0d filled %0d index %0d priority %0d count %0d last %0d",
                     rank, slot_filled, chosen_index, chosen_priority, selected_count,
                     last_result);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    entry_row_t directed[$];
    entry_row_t step;
    prio_mode_t prio_mode;
    int         counted;
    int         scan;
    int         len;

    clk            = 1'b0;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    entry_index    = '0;
    entry_priority = '0;
    entry_present  = 1'b0;
    last_entry     = 1'b0;
    out_ready      = 1'b0;
    quiet_in       = 1'b0;
    quiet_out      = 1'b0;
    ready_run      = 0;
    ready_level    = 1'b0;
    mismatches     = 0;
    model_top_count = TOP_COUNT_RESET;
    clear_slots();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Columns: cfg write, cfg value, index, priority,
    // present, last, typed, typed count, typed rank 0 index, rank 0 priority.
    // Reset value of top_count: an absent last entry empties all 16 ranks
    directed.push_back(mk_row(0, 0,  12'd0,    16'd0,     0, 1, 1, 5'd0, 12'd0,    16'd0));
    // Extremes, present last entry goes in before the words come out
    directed.push_back(mk_row(0, 0,  12'd4095, 16'd65535, 1, 1, 1, 5'd1, 12'd4095, 16'd65535));
    // Sorted inserts, an equal priority behind the first, a skipped entry
    directed.push_back(mk_row(0, 0,  12'd0,    16'd0,     1, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(0, 0,  12'd5,    16'd100,   1, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(0, 0,  12'd6,    16'd100,   1, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(0, 0,  12'd4095, 16'd65535, 0, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(0, 0,  12'd7,    16'd50,    1, 1, 0, 5'd0, 12'd0,    16'd0));
    // top_count of zero acts as one: ties and lower entries drop on a full list
    directed.push_back(mk_row(1, 0,  12'd10,   16'd300,   1, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(0, 0,  12'd11,   16'd300,   1, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(0, 0,  12'd12,   16'd200,   1, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(0, 0,  12'd13,   16'd400,   1, 1, 1, 5'd1, 12'd13,   16'd400));
    // top_count above the row length saturates to 16 ranks
    directed.push_back(mk_row(1, 31, 12'd1,    16'd1,     1, 1, 1, 5'd1, 12'd1,    16'd1));
    // Shrink mid scan: the third slot is hidden, then comes back still in order
    directed.push_back(mk_row(1, 4,  12'd20,   16'd10,    1, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(0, 0,  12'd21,   16'd30,    1, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(0, 0,  12'd22,   16'd20,    1, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(1, 2,  12'd23,   16'd25,    1, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(0, 0,  12'd24,   16'd5,     1, 0, 0, 5'd0, 12'd0,    16'd0));
    directed.push_back(mk_row(1, 4,  12'd25,   16'd1,     1, 1, 0, 5'd0, 12'd0,    16'd0));

    foreach (directed[i]) begin
      if (directed[i].cfg_wr) write_top_count(directed[i].cfg_val);
      send_entry(directed[i]);
    end

    // Random scans. Each is a well-formed run of entries closed by a last
    // entry; every entry word sent counts toward the total.
    counted = 0;
    scan    = 0;
    while (counted < RANDOM_ITEMS) begin
      if (scan == 0) write_top_count(5'd1);
      else if (scan == 1) write_top_count(5'd16);
      else if ($urandom_range(0, 2) == 0) write_top_count(pick_top_count());
      quiet_in  = ($urandom_range(0, 4) == 0);
      quiet_out = ($urandom_range(0, 4) == 0);
      prio_mode = prio_mode_t'($urandom_range(0, 2));
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        step = mk_row(0, 0, IDX_W'($urandom_range(0, 4095)), pick_prio(prio_mode),
                      ($urandom_range(0, 3) != 0), (i == len - 1), 0, 0, 0, 0);
        send_entry(step);
        counted++;
        // resize now and then in the middle of a scan
        if (!step.last && $urandom_range(0, 39) == 0) write_top_count(pick_top_count());
      end
      // hold the sender until the whole ranking has drained
      if (scan == 2 || $urandom_range(0, 3) == 0) settle();
      scan++;
    end

    quiet_in = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && ranking_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Generous bound: far beyond the slowest legal run of this stimulus
  initial begin
    #5_000_000;
    $display("timeout: result words still owed: %0d", ranking_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tkps_pkg.sv
rtl/tkps_cell.sv
rtl/top_k_priority_select.sv
verif/top_k_priority_select_tb.sv
